[rtl/core/ps2mc_pkg.sv]
package ps2mc_pkg;

    // Coordinate width default and config register width
    localparam int COORD_BITS_DEF = 12;
    localparam int CFG_W          = 12;
    localparam int CFG_IDX_W      = 3;

    // Register reset values
    localparam logic [CFG_W-1:0] MAX_X_RST = 12'd1140;
    localparam logic [CFG_W-1:0] MAX_Y_RST = 12'd850;

    // Header bit positions
    localparam int HDR_LEFT   = 0;
    localparam int HDR_RIGHT  = 1;
    localparam int HDR_MIDDLE = 2;
    localparam int HDR_SYNC   = 3;
    localparam int HDR_XSIGN  = 4;
    localparam int HDR_YSIGN  = 5;
    localparam int HDR_XOVF   = 6;
    localparam int HDR_YOVF   = 7;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_X       = 3'd0,
        REG_MAX_Y       = 3'd1,
        REG_REGION_X_LO = 3'd2,
        REG_REGION_X_HI = 3'd3,
        REG_REGION_Y_LO = 3'd4,
        REG_REGION_Y_HI = 3'd5
    } cfg_reg_t;

    // Position within a packet
    typedef enum logic [1:0] {
        CNT_HEADER = 2'd0,
        CNT_X      = 2'd1,
        CNT_Y      = 2'd2,
        CNT_SPARE  = 2'd3
    } byte_cnt_t;

endpackage

[rtl/core/ps2_mouse_packet_cursor.sv]
// Channel  Dir  Beat fields (lowest bit up)
// s_axis   in   tdata: data_byte[7:0]; tuser: rx_error
// m_axis   out  tdata: left_button, right_button, middle_button, delta_x[8:0],
//               delta_y[8:0], x_ovf, y_ovf, cursor_x, cursor_y, in_region
// cfg      in   cfg_we, cfg_index, cfg_wdata (one register per write)
//
// One input beat is taken every cycle while s_tready is high; the third byte of a
// packet loads its result beat into the output register.
// The cursor add, clamp and rectangle compare are combinational, ahead of that register.
// Reset clears the packet position, cursor and output valid; registers reload defaults.
// s_tready drops only while a result is held and m_tready is low.
module ps2_mouse_packet_cursor #(
    parameter int COORD_BITS = ps2mc_pkg::COORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // data_byte[7:0]
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,
    // rx_error
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // left_button, right_button, middle_button, delta_x[8:0], delta_y[8:0],
    // x_ovf, y_ovf, cursor_x, cursor_y, in_region, zero fill
    output logic [((24 + 2 * COORD_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    input  logic                              cfg_we,
    input  logic [ps2mc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ps2mc_pkg::CFG_W-1:0]       cfg_wdata
);
    import ps2mc_pkg::*;

    localparam int OUT_BITS = 24 + 2 * COORD_BITS;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
    localparam int LW       = (COORD_BITS > CFG_W) ? COORD_BITS : CFG_W;
    localparam int CW       = LW + 2;
    localparam logic [LW-1:0] COORD_MASK = LW'((1 << COORD_BITS) - 1);

    logic [CFG_W-1:0]      max_x_reg, max_y_reg;
    logic [CFG_W-1:0]      rx_lo_reg, rx_hi_reg, ry_lo_reg, ry_hi_reg;
    byte_cnt_t             cnt_reg, cnt_next;
    logic [7:0]            hdr_reg, hdr_next;
    logic [7:0]            xb_reg, xb_next;
    logic [COORD_BITS-1:0] pos_x_reg, pos_x_next;
    logic [COORD_BITS-1:0] pos_y_reg, pos_y_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_BITS-1:0]   out_data_reg, out_data_next;

    logic                  in_beat;
    logic                  done;
    logic signed [8:0]     dx, dy;
    logic [LW-1:0]         lim_x, lim_y;
    logic signed [CW-1:0]  sum_x, sum_y;
    logic [COORD_BITS-1:0] clamp_x, clamp_y;
    logic                  in_rect;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_x_reg <= MAX_X_RST;
            max_y_reg <= MAX_Y_RST;
            rx_lo_reg <= '0;
            rx_hi_reg <= '0;
            ry_lo_reg <= '0;
            ry_hi_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_X:       max_x_reg <= cfg_wdata;
                REG_MAX_Y:       max_y_reg <= cfg_wdata;
                REG_REGION_X_LO: rx_lo_reg <= cfg_wdata;
                REG_REGION_X_HI: rx_hi_reg <= cfg_wdata;
                REG_REGION_Y_LO: ry_lo_reg <= cfg_wdata;
                REG_REGION_Y_HI: ry_hi_reg <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    assign s_tready = !out_valid_reg || m_tready;
    assign in_beat  = s_tvalid && s_tready;

    // Decode deltas of the packet being completed
    assign dx = {hdr_reg[HDR_XSIGN], xb_reg};
    assign dy = {hdr_reg[HDR_YSIGN], s_tdata};

    // Effective maxima, limited to the coordinate range
    assign lim_x = (LW'(max_x_reg) < COORD_MASK) ? LW'(max_x_reg) : COORD_MASK;
    assign lim_y = (LW'(max_y_reg) < COORD_MASK) ? LW'(max_y_reg) : COORD_MASK;

    // Move and clamp each axis
    assign sum_x = $signed(CW'(pos_x_reg)) + CW'(dx);
    assign sum_y = $signed(CW'(pos_y_reg)) - CW'(dy);

    always_comb
    begin
        if (sum_x < 0)
            clamp_x = '0;
        else if (sum_x > $signed(CW'(lim_x)))
            clamp_x = lim_x[COORD_BITS-1:0];
        else
            clamp_x = sum_x[COORD_BITS-1:0];

        if (sum_y < 0)
            clamp_y = '0;
        else if (sum_y > $signed(CW'(lim_y)))
            clamp_y = lim_y[COORD_BITS-1:0];
        else
            clamp_y = sum_y[COORD_BITS-1:0];
    end

    // Hold an axis whose overflow bit is set
    assign pos_x_next = hdr_reg[HDR_XOVF] ? pos_x_reg : clamp_x;
    assign pos_y_next = hdr_reg[HDR_YOVF] ? pos_y_reg : clamp_y;

    assign in_rect = (LW'(pos_x_next) >= LW'(rx_lo_reg)) &&
                     (LW'(pos_x_next) <= LW'(rx_hi_reg)) &&
                     (LW'(pos_y_next) >= LW'(ry_lo_reg)) &&
                     (LW'(pos_y_next) <= LW'(ry_hi_reg));

    // Advance the packet position; drop errored bytes and unsynced headers
    always_comb
    begin
        cnt_next = cnt_reg;
        hdr_next = hdr_reg;
        xb_next  = xb_reg;
        done     = 1'b0;
        if (in_beat && !s_tuser)
        begin
            unique case (cnt_reg)
                CNT_HEADER:
                begin
                    if (s_tdata[HDR_SYNC])
                    begin
                        hdr_next = s_tdata;
                        cnt_next = CNT_X;
                    end
                end
                CNT_X:
                begin
                    xb_next  = s_tdata;
                    cnt_next = CNT_Y;
                end
                default:
                begin
                    cnt_next = CNT_HEADER;
                    done     = 1'b1;
                end
            endcase
        end
    end

    // Load or drain the output register
    always_comb
    begin
        out_data_next  = {in_rect, pos_y_next, pos_x_next,
                          hdr_reg[HDR_YOVF], hdr_reg[HDR_XOVF],
                          dy, dx,
                          hdr_reg[HDR_MIDDLE], hdr_reg[HDR_RIGHT], hdr_reg[HDR_LEFT]};
        out_valid_next = out_valid_reg;
        if (done)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= CNT_HEADER;
            hdr_reg       <= '0;
            xb_reg        <= '0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            hdr_reg       <= hdr_next;
            xb_reg        <= xb_next;
            out_valid_reg <= out_valid_next;
            if (done)
            begin
                pos_x_reg <= pos_x_next;
                pos_y_reg <= pos_y_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
            out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(out_data_reg);

endmodule
